// File: hdl/crse_pkg.sv
// Shared types, constants and a helper function for the character range expander.
`default_nettype none

package crse_pkg;

   // Dash character that joins the two ends of a range.
   localparam logic [7:0] DASH_CHAR = 8'h2D;

   // Queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Input request payload.
   typedef struct packed {
      logic [7:0] in_char;
      logic       is_final;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   // Character class of a range end.
   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_DIGIT = 2'd1,
      CLS_LOWER = 2'd2,
      CLS_UPPER = 2'd3
   } char_class_type;

   // Emit command for one request: an optional held character, an optional
   // dash, then the run run_lo..run_hi (one character when both are equal).
   typedef struct packed {
      logic       pre_char_valid;
      logic [7:0] pre_char;
      logic       pre_dash_valid;
      logic [7:0] run_lo;
      logic [7:0] run_hi;
      logic       is_final;
   } cmd_type;

   // Classify a character for range checks.
   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      cls = CLS_OTHER;
      if (c >= 8'h30 && c <= 8'h39) begin
         cls = CLS_DIGIT;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         cls = CLS_LOWER;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         cls = CLS_UPPER;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

// File: hdl/char_range_shorthand_expander_core.sv
// Top level of the character range expander: front, command queue and back.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_type (in_char, is_final)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (out_char, run_last, string_done)
//
// The front takes one request per cycle while the two-entry command queue has room.
// The back writes one character per cycle while rsp_stall is low; a request yields
// up to 26 characters (for a letter range), so the back's output port sets the rate.
// A request that yields no character stays in the front and never enters the queue.
// Reset clears the string state, the queue and the output register's valid flag at once.
// A stall on rsp_ fills the queue and then raises req_stall; the halves stall on their own.
`default_nettype none

module char_range_shorthand_expander_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire crse_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output crse_pkg::rsp_type      rsp_payload
);

   logic              req_accept;
   logic              push;
   crse_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              head_valid;
   crse_pkg::cmd_type head_cmd;
   logic              pop;

   // The request side stalls only on a full queue.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   crse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_payload (req_payload),
      .push        (push),
      .cmd         (push_cmd)
   );

   crse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   crse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: hdl/crse_front.sv
// Front part: accepts characters, tracks the string state and builds emit commands.
`default_nettype none

module crse_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire crse_pkg::req_type req_payload,
   output logic                   push,
   output crse_pkg::cmd_type      cmd
);

   logic [7:0] pend_start_ff, pend_start_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [1:0] pend_age_ff, pend_age_in;
   logic [7:0] prev_char_ff, prev_char_in;
   logic       at_start_ff, at_start_in;

   logic [7:0] c;
   logic       last;
   logic       is_dash;
   logic       prev_dash;
   logic       absorb;
   logic       is_range;
   logic       capture;
   logic       fall;
   logic       range_ok;
   crse_pkg::char_class_type start_cls;

   // Classify the incoming character against the held state.
   always_comb begin
      c         = req_payload.in_char;
      last      = req_payload.is_final;
      is_dash   = (c == crse_pkg::DASH_CHAR);
      prev_dash = (prev_char_ff == crse_pkg::DASH_CHAR);
      absorb    = is_dash && !at_start_ff && !last && pend_valid_ff && (pend_age_ff == 2'd0);
      is_range  = !is_dash && pend_valid_ff && prev_dash && (pend_age_ff == 2'd1);
      capture   = !is_dash && !pend_valid_ff;
      fall      = !absorb && !is_range && !capture;
      start_cls = crse_pkg::char_class(pend_start_ff);
      range_ok  = (start_cls != crse_pkg::CLS_OTHER) &&
                  (start_cls == crse_pkg::char_class(c)) && (pend_start_ff <= c);
   end

   // Build the emit command for this request.
   always_comb begin
      cmd.pre_char_valid = 1'b0;
      cmd.pre_char       = pend_start_ff;
      cmd.pre_dash_valid = 1'b0;
      cmd.run_lo         = c;
      cmd.run_hi         = c;
      cmd.is_final       = last;
      if (is_range) begin
         if (range_ok) begin
            cmd.run_lo = pend_start_ff;
         end else begin
            cmd.pre_char_valid = 1'b1;
            cmd.pre_dash_valid = 1'b1;
         end
      end else if (fall) begin
         cmd.pre_char_valid = pend_valid_ff;
         cmd.pre_dash_valid = prev_dash;
      end
      push = accept && (is_range || fall || (capture && last));
   end

   // Next string state.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_age_in   = pend_age_ff;
      prev_char_in  = prev_char_ff;
      at_start_in   = at_start_ff;
      if (accept) begin
         if (last) begin
            pend_valid_in = 1'b0;
            pend_start_in = 8'd0;
            pend_age_in   = 2'd0;
            prev_char_in  = 8'd0;
            at_start_in   = 1'b1;
         end else begin
            if (capture) begin
               pend_valid_in = 1'b1;
               pend_start_in = c;
               pend_age_in   = 2'd0;
            end else begin
               if (is_range || fall) begin
                  pend_valid_in = 1'b0;
                  pend_start_in = 8'd0;
               end
               if (pend_age_ff != 2'd3) begin
                  pend_age_in = pend_age_ff + 2'd1;
               end
            end
            prev_char_in = c;
            at_start_in  = 1'b0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_start_ff <= 8'd0;
         pend_age_ff   <= 2'd0;
         prev_char_ff  <= 8'd0;
         at_start_ff   <= 1'b1;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_start_ff <= pend_start_in;
         pend_age_ff   <= pend_age_in;
         prev_char_ff  <= prev_char_in;
         at_start_ff   <= at_start_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/crse_queue.sv
// Short command queue between the front and back parts.
`default_nettype none

module crse_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire crse_pkg::cmd_type push_cmd,
   output logic                   full,
   output logic                   head_valid,
   output crse_pkg::cmd_type      head_cmd,
   input  wire logic              pop
);

   crse_pkg::cmd_type entries_ff [crse_pkg::QUEUE_DEPTH];
   logic [crse_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crse_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crse_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   // Status and head of the queue.
   always_comb begin
      full       = (count_ff == crse_pkg::QUEUE_CNT_W'(crse_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entries_ff[rd_ptr_ff];
   end

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == crse_pkg::QUEUE_PTR_W'(crse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == crse_pkg::QUEUE_PTR_W'(crse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hdl/crse_back.sv
// Back part: emit commands go to the output register one character per free cycle.
`default_nettype none

module crse_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire crse_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output crse_pkg::rsp_type      rsp_payload
);

   logic              active_ff, active_in;
   crse_pkg::cmd_type cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   crse_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic out_free;
   logic emit;
   logic run_end;
   logic final_emit;

   // Pick the next character of the current command.
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = active_ff && out_free;
      run_end    = !cur_ff.pre_char_valid && !cur_ff.pre_dash_valid &&
                   (cur_ff.run_lo == cur_ff.run_hi);
      final_emit = emit && run_end;
      cmd_pop    = cmd_valid && (!active_ff || final_emit);
   end

   // Advance through the command, loading the next one as the last character leaves.
   always_comb begin
      active_in = active_ff;
      cur_in    = cur_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         cur_in    = cmd;
      end else if (final_emit) begin
         active_in = 1'b0;
      end else if (emit) begin
         if (cur_ff.pre_char_valid) begin
            cur_in.pre_char_valid = 1'b0;
         end else if (cur_ff.pre_dash_valid) begin
            cur_in.pre_dash_valid = 1'b0;
         end else begin
            cur_in.run_lo = cur_ff.run_lo + 8'd1;
         end
      end
   end

   // Output register contents.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         if (cur_ff.pre_char_valid) begin
            rsp_payload_in.out_char = cur_ff.pre_char;
         end else if (cur_ff.pre_dash_valid) begin
            rsp_payload_in.out_char = crse_pkg::DASH_CHAR;
         end else begin
            rsp_payload_in.out_char = cur_ff.run_lo;
         end
         rsp_payload_in.run_last    = run_end;
         rsp_payload_in.string_done = run_end && cur_ff.is_final;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the character range shorthand expander core.
`default_nettype none

module tb;

   localparam int RANDOM_ITEMS = 285;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   crse_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   crse_pkg::rsp_type rsp_payload;

   // Requests waiting to be driven and characters waiting to come out.
   crse_pkg::req_type pending_reqs[$];
   crse_pkg::rsp_type expected_chars[$];

   int failures = 0;
   int idle_cycles = 0;

   // Expander state as the predictor tracks it.
   logic [7:0] held_char = 8'h00;
   logic       held_valid = 1'b0;
   logic [1:0] held_age = 2'd0;
   logic [7:0] prev_char = 8'h00;
   logic       at_start = 1'b1;

   char_range_shorthand_expander_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Class of a range end; anything outside the three classes never forms a range.
   function automatic crse_pkg::char_class_type range_kind(input logic [7:0] c);
      if (c >= "0" && c <= "9") return crse_pkg::CLS_DIGIT;
      if (c >= "a" && c <= "z") return crse_pkg::CLS_LOWER;
      if (c >= "A" && c <= "Z") return crse_pkg::CLS_UPPER;
      return crse_pkg::CLS_OTHER;
   endfunction

   // Works out the characters one accepted request yields and queues them.
   task automatic expand_request(input crse_pkg::req_type r);
      logic [7:0]        c;
      logic              fin;
      logic              spill;
      logic              took;
      logic [7:0]        run[$];
      int                k;
      crse_pkg::rsp_type e;
      c = r.in_char;
      fin = r.is_final;
      spill = 1'b1;
      took = 1'b0;
      if (c == crse_pkg::DASH_CHAR) begin
         // A dash right after a held start is absorbed as a range joiner.
         if (!at_start && !fin && held_valid && held_age == 2'd0) spill = 1'b0;
      end else if (held_valid) begin
         if (prev_char == crse_pkg::DASH_CHAR && held_age == 2'd1) begin
            if (range_kind(held_char) != crse_pkg::CLS_OTHER &&
                range_kind(held_char) == range_kind(c) && held_char <= c) begin
               for (k = int'(held_char); k <= int'(c); k++) run.push_back(k[7:0]);
            end else begin
               run.push_back(held_char);
               run.push_back(crse_pkg::DASH_CHAR);
               run.push_back(c);
            end
            held_valid = 1'b0;
            held_char = 8'h00;
            spill = 1'b0;
         end
      end else begin
         held_char = c;
         held_valid = 1'b1;
         held_age = 2'd0;
         took = 1'b1;
         spill = 1'b0;
      end
      // Anything not consumed above goes out literally.
      if (spill) begin
         if (held_valid) begin
            run.push_back(held_char);
            held_valid = 1'b0;
            held_char = 8'h00;
         end
         if (prev_char == crse_pkg::DASH_CHAR) run.push_back(crse_pkg::DASH_CHAR);
         run.push_back(c);
      end
      if (!took && held_age != 2'd3) held_age = held_age + 2'd1;
      prev_char = c;
      at_start = 1'b0;
      // The end of the string flushes a held start and clears the state.
      if (fin) begin
         if (held_valid) run.push_back(held_char);
         held_char = 8'h00;
         held_valid = 1'b0;
         held_age = 2'd0;
         prev_char = 8'h00;
         at_start = 1'b1;
      end
      for (k = 0; k < run.size(); k++) begin
         e.out_char = run[k];
         e.run_last = (k == run.size() - 1);
         e.string_done = fin && (k == run.size() - 1);
         expected_chars.push_back(e);
      end
   endtask

   // Queues a whole string, marking its last character.
   task automatic queue_text(input logic [7:0] text[$]);
      crse_pkg::req_type r;
      int                i;
      for (i = 0; i < text.size(); i++) begin
         r.in_char = text[i];
         r.is_final = (i == text.size() - 1);
         pending_reqs.push_back(r);
      end
   endtask

   task automatic queue_literal(input string s);
      logic [7:0] text[$];
      int         i;
      for (i = 0; i < s.len(); i++) text.push_back(s[i]);
      queue_text(text);
   endtask

   function automatic int class_base(input crse_pkg::char_class_type k);
      case (k)
         crse_pkg::CLS_DIGIT: return 'h30;
         crse_pkg::CLS_LOWER: return 'h61;
         default:             return 'h41;
      endcase
   endfunction

   function automatic int class_top(input crse_pkg::char_class_type k);
      case (k)
         crse_pkg::CLS_DIGIT: return 'h39;
         crse_pkg::CLS_LOWER: return 'h7A;
         default:             return 'h5A;
      endcase
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      logic              nv;
      crse_pkg::req_type np;
      nv = req_valid;
      np = req_payload;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expand_request(req_payload);
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
               np = pending_reqs.pop_front();
               nv = 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= nv;
      req_payload <= np;
   end

   // Result monitor and receiver stall pattern.
   int stall_mode = 0;
   int stall_phase_left = 0;
   int stall_tick = 0;

   always @(posedge clock) begin : rsp_monitor
      crse_pkg::rsp_type want;
      logic              ns;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected result: out_char %h run_last %b string_done %b",
                   rsp_payload.out_char, rsp_payload.run_last, rsp_payload.string_done);
            failures++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.out_char !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_payload.out_char);
               failures++;
            end
            if (rsp_payload.run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_payload.run_last);
               failures++;
            end
            if (rsp_payload.string_done !== want.string_done) begin
               $error("string_done: expected %b, got %b", want.string_done,
                      rsp_payload.string_done);
               failures++;
            end
         end
      end
      // The stall pattern changes mode every so often: none, light, heavy, periodic.
      if (stall_phase_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_phase_left = $urandom_range(20, 200);
      end else begin
         stall_phase_left = stall_phase_left - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         1:       ns = ($urandom_range(0, 3) == 0);
         2:       ns = ($urandom_range(0, 4) != 0);
         3:       ns = ((stall_tick % 7) < 3);
         default: ns = 1'b0;
      endcase
      rsp_stall <= reset ? 1'b0 : ns;
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin : idle_watch
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0]               text[$];
      int                       made;
      int                       tokens;
      int                       t;
      int                       lo;
      int                       hi;
      int                       w;
      crse_pkg::char_class_type k;
      logic [1:0]               kbits;

      // Directed strings: valid runs, the longest run, reversed and mixed-class
      // ranges, leading, trailing and repeated dashes, extreme codes, a lone dash.
      queue_literal("a-fA-Z");
      queue_literal("z-a");
      queue_literal("9-A");
      queue_literal("-a-");
      queue_literal("b--c");
      text = {8'h00};
      queue_text(text);
      text = {8'hFF, crse_pkg::DASH_CHAR, 8'h80};
      queue_text(text);
      queue_literal("-");

      // Random strings, mostly built from range shorthand with random content.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         text = {};
         tokens = $urandom_range(1, 4);
         for (t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  kbits = 2'($urandom_range(1, 3));
                  k = crse_pkg::char_class_type'(kbits);
                  lo = class_base(k) + $urandom_range(0, class_top(k) - class_base(k));
                  case ($urandom_range(0, 15))
                     0: begin
                        lo = class_base(k);
                        hi = class_top(k);
                     end
                     1, 2: hi = $urandom_range(0, 255);
                     3: hi = class_base(k) + $urandom_range(0, class_top(k) - class_base(k));
                     default: begin
                        w = $urandom_range(0, 4);
                        hi = (lo + w > class_top(k)) ? class_top(k) : lo + w;
                     end
                  endcase
                  text.push_back(lo[7:0]);
                  text.push_back(crse_pkg::DASH_CHAR);
                  text.push_back(hi[7:0]);
               end
               6: begin
                  kbits = 2'($urandom_range(1, 3));
                  k = crse_pkg::char_class_type'(kbits);
                  lo = class_base(k) + $urandom_range(0, class_top(k) - class_base(k));
                  text.push_back(lo[7:0]);
               end
               7: text.push_back(crse_pkg::DASH_CHAR);
               8: text.push_back(8'($urandom_range(0, 255)));
               default: begin
                  text.push_back(8'($urandom_range(0, 255)));
                  text.push_back(crse_pkg::DASH_CHAR);
               end
            endcase
         end
         made = made + text.size();
         queue_text(text);
      end

      // Hold reset, then release it and let the driver and monitor run.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (!(pending_reqs.size() == 0 && !req_valid && expected_chars.size() == 0)
             && idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
      end
      if (idle_cycles < IDLE_LIMIT) begin
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      if (idle_cycles < IDLE_LIMIT && failures == 0 && expected_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hdl/crse_pkg.sv
hdl/crse_front.sv
hdl/crse_queue.sv
hdl/crse_back.sv
hdl/char_range_shorthand_expander_core.sv
tb/sv/tb.sv
